### rtl/dofe_pkg.sv
// dofe_pkg: types, constants and helpers for the dhcp option field extractor
// shared by the front, queue, back and top-level modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dofe_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] CodePad       = 8'd0;
  localparam logic [7:0] CodeEnd       = 8'd255;
  localparam logic [7:0] CodeSubnet    = 8'd1;
  localparam logic [7:0] CodeRouter    = 8'd3;
  localparam logic [7:0] CodeDns       = 8'd6;
  localparam logic [7:0] CodeCookie    = 8'd99;
  localparam logic [7:0] CodeMsgType   = 8'd53;
  localparam logic [7:0] CodeServerId  = 8'd54;

  localparam logic [7:0] CookieByte0 = 8'd99;
  localparam logic [7:0] CookieByte1 = 8'd130;
  localparam logic [7:0] CookieByte2 = 8'd83;
  localparam logic [7:0] CookieByte3 = 8'd99;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_NO_TYPE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       restart;
    logic       short_stream;
  } queue_entry_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CookieByte0;
      2'd1:    b = CookieByte1;
      2'd2:    b = CookieByte2;
      default: b = CookieByte3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/dofe_front.sv
// dofe_front: accepts option-area bytes, tracks position and the magic cookie
// depends on dofe_pkg
`timescale 1ns / 1ps
`default_nettype none

module dofe_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output dofe_pkg::queue_entry_t     push_entry_o
);

  logic [2:0] byte_index_q, byte_index_d;
  logic       cookie_match_q, cookie_match_d;
  logic       in_head;
  logic       match_now;
  logic       accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;
  assign in_head      = (byte_index_q < 3'd4);

  always_comb begin
    match_now = cookie_match_q;
    if (in_head && (data_byte_i != dofe_pkg::cookie_byte(byte_index_q[1:0]))) begin
      match_now = 1'b0;
    end
  end

  always_comb begin
    push_entry_o.data_byte    = data_byte_i;
    push_entry_o.last         = last_i;
    push_entry_o.restart      = (byte_index_q == 3'd3) && match_now;
    push_entry_o.short_stream = (byte_index_q < 3'd3);
  end

  always_comb begin
    byte_index_d   = byte_index_q;
    cookie_match_d = cookie_match_q;
    if (accept) begin
      if (last_i) begin
        byte_index_d   = 3'd0;
        cookie_match_d = 1'b1;
      end else begin
        cookie_match_d = match_now;
        if (in_head) begin
          byte_index_d = byte_index_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= 3'd0;
      cookie_match_q <= 1'b1;
    end else begin
      byte_index_q   <= byte_index_d;
      cookie_match_q <= cookie_match_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dofe_queue.sv
// dofe_queue: small register fifo of classified bytes between front and back
// depends on dofe_pkg
`timescale 1ns / 1ps
`default_nettype none

module dofe_queue #(
  parameter int unsigned Depth = dofe_pkg::QueueDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output logic                       push_ready_o,
  input  wire dofe_pkg::queue_entry_t push_entry_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_ready_i,
  output dofe_pkg::queue_entry_t     pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dofe_pkg::queue_entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/dofe_back.sv
// dofe_back: option tlv parser, captured fields and the result register
// depends on dofe_pkg
`timescale 1ns / 1ps
`default_nettype none

module dofe_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pop_valid_i,
  output logic                        pop_ready_o,
  input  wire dofe_pkg::queue_entry_t pop_entry_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic [7:0]                  dhcp_type_o,
  output logic [31:0]                 subnet_mask_o,
  output logic [31:0]                 router_o,
  output logic [31:0]                 dns_server_o,
  output logic [31:0]                 server_ident_o
);

  dofe_pkg::phase_e phase_q, phase_d;
  logic [7:0]  option_code_q, option_code_d;
  logic [7:0]  option_length_q, option_length_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [31:0] value_accum_q, value_accum_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [31:0] held_mask_q, held_mask_d;
  logic [31:0] held_router_q, held_router_d;
  logic [31:0] held_dns_q, held_dns_d;
  logic [31:0] held_server_q, held_server_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  dhcp_type_q, dhcp_type_d;
  logic [31:0] subnet_mask_q, subnet_mask_d;
  logic [31:0] router_q, router_d;
  logic [31:0] dns_server_q, dns_server_d;
  logic [31:0] server_ident_q, server_ident_d;

  logic        fire;
  logic        out_free;
  logic [7:0]  b;
  logic [7:0]  pos;
  logic [31:0] accum_new;
  logic [7:0]  left_new;
  logic        bad;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = !pop_entry_i.last || out_free;
  assign fire        = pop_valid_i && pop_ready_o;
  assign b           = pop_entry_i.data_byte;
  assign pos         = option_length_q - bytes_left_q;
  assign accum_new   = (pos < 8'd4) ? {value_accum_q[23:0], b} : value_accum_q;
  assign left_new    = bytes_left_q - 8'd1;

  always_comb begin
    phase_d         = phase_q;
    option_code_d   = option_code_q;
    option_length_d = option_length_q;
    bytes_left_d    = bytes_left_q;
    value_accum_d   = value_accum_q;
    held_type_d     = held_type_q;
    held_mask_d     = held_mask_q;
    held_router_d   = held_router_q;
    held_dns_d      = held_dns_q;
    held_server_d   = held_server_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    status_d        = status_q;
    dhcp_type_d     = dhcp_type_q;
    subnet_mask_d   = subnet_mask_q;
    router_d        = router_q;
    dns_server_d    = dns_server_q;
    server_ident_d  = server_ident_q;
    bad             = 1'b0;

    if (fire) begin
      case (phase_q)
        dofe_pkg::PH_CODE: begin
          if (b == dofe_pkg::CodeEnd) begin
            phase_d = dofe_pkg::PH_DONE;
          end else if (b != dofe_pkg::CodePad) begin
            option_code_d = b;
            phase_d       = dofe_pkg::PH_LEN;
          end
        end
        dofe_pkg::PH_LEN: begin
          option_length_d = b;
          bytes_left_d    = b;
          value_accum_d   = '0;
          phase_d         = (b == 8'd0) ? dofe_pkg::PH_CODE : dofe_pkg::PH_VALUE;
        end
        dofe_pkg::PH_VALUE: begin
          value_accum_d = accum_new;
          if (pos == 8'd0 && option_code_q == dofe_pkg::CodeMsgType &&
              option_length_q == 8'd1) begin
            held_type_d = b;
          end
          if (pos == 8'd3) begin
            if (option_code_q == dofe_pkg::CodeSubnet && option_length_q == 8'd4) begin
              held_mask_d = accum_new;
            end else if (option_code_q == dofe_pkg::CodeRouter) begin
              held_router_d = accum_new;
            end else if (option_code_q == dofe_pkg::CodeDns) begin
              held_dns_d = accum_new;
            end else if (option_code_q == dofe_pkg::CodeServerId &&
                         option_length_q == 8'd4) begin
              held_server_d = accum_new;
            end
          end
          bytes_left_d = left_new;
          if (left_new == 8'd0) begin
            phase_d = dofe_pkg::PH_CODE;
          end
        end
        default: begin
        end
      endcase

      // cookie recognized: drop the parse of the first four bytes
      if (pop_entry_i.restart) begin
        phase_d         = dofe_pkg::PH_CODE;
        bytes_left_d    = '0;
        option_length_d = '0;
        option_code_d   = '0;
        value_accum_d   = '0;
      end

      if (pop_entry_i.last) begin
        bad = pop_entry_i.short_stream || (phase_d == dofe_pkg::PH_LEN) ||
              (phase_d == dofe_pkg::PH_VALUE);
        out_valid_d = 1'b1;
        if (bad) begin
          status_d       = dofe_pkg::STATUS_MALFORMED;
          dhcp_type_d    = '0;
          subnet_mask_d  = '0;
          router_d       = '0;
          dns_server_d   = '0;
          server_ident_d = '0;
        end else begin
          status_d       = (held_type_d == 8'd0) ? dofe_pkg::STATUS_NO_TYPE
                                                 : dofe_pkg::STATUS_OK;
          dhcp_type_d    = held_type_d;
          subnet_mask_d  = held_mask_d;
          router_d       = held_router_d;
          dns_server_d   = held_dns_d;
          server_ident_d = held_server_d;
        end
        phase_d         = dofe_pkg::PH_CODE;
        option_code_d   = '0;
        option_length_d = '0;
        bytes_left_d    = '0;
        value_accum_d   = '0;
        held_type_d     = '0;
        held_mask_d     = '0;
        held_router_d   = '0;
        held_dns_d      = '0;
        held_server_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= dofe_pkg::PH_CODE;
      option_code_q   <= '0;
      option_length_q <= '0;
      bytes_left_q    <= '0;
      value_accum_q   <= '0;
      held_type_q     <= '0;
      held_mask_q     <= '0;
      held_router_q   <= '0;
      held_dns_q      <= '0;
      held_server_q   <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      option_code_q   <= option_code_d;
      option_length_q <= option_length_d;
      bytes_left_q    <= bytes_left_d;
      value_accum_q   <= value_accum_d;
      held_type_q     <= held_type_d;
      held_mask_q     <= held_mask_d;
      held_router_q   <= held_router_d;
      held_dns_q      <= held_dns_d;
      held_server_q   <= held_server_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q       <= status_d;
    dhcp_type_q    <= dhcp_type_d;
    subnet_mask_q  <= subnet_mask_d;
    router_q       <= router_d;
    dns_server_q   <= dns_server_d;
    server_ident_q <= server_ident_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign dhcp_type_o    = dhcp_type_q;
  assign subnet_mask_o  = subnet_mask_q;
  assign router_o       = router_q;
  assign dns_server_o   = dns_server_q;
  assign server_ident_o = server_ident_q;

endmodule

`default_nettype wire

### rtl/dhcp_option_field_extractor.sv
// dhcp_option_field_extractor: top level of the dhcp options field extractor
// depends on dofe_pkg, dofe_front, dofe_queue and dofe_back
`timescale 1ns / 1ps
`default_nettype none

// Takes the DHCP options area one byte per transaction, last_i marking the
// final byte, and returns one result transaction per options area holding the
// message type, subnet mask, router, DNS server and server identifier, with a
// status (0 ok, 1 malformed or truncated, 2 message type zero or absent). A
// leading magic cookie is skipped. The block takes one byte per clock cycle
// while the queue has room; every byte is written into the QueueDepth-entry
// queue and is parsed as it leaves, so the result of a final byte is loaded
// into the output register as that byte is popped from the queue. Bytes keep
// flowing while a result waits; a further final byte waits at the head of the
// queue until the output register is emptied, and input stalls once the queue
// is full behind it.
module dhcp_option_field_extractor #(
  parameter int unsigned QueueDepth = dofe_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       dhcp_type_o,
  output logic [31:0]      subnet_mask_o,
  output logic [31:0]      router_o,
  output logic [31:0]      dns_server_o,
  output logic [31:0]      server_ident_o
);

  logic                   push_valid, push_ready;
  dofe_pkg::queue_entry_t push_entry;
  logic                   pop_valid, pop_ready;
  dofe_pkg::queue_entry_t pop_entry;

  dofe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dofe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  dofe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .dhcp_type_o    (dhcp_type_o),
    .subnet_mask_o  (subnet_mask_o),
    .router_o       (router_o),
    .dns_server_o   (dns_server_o),
    .server_ident_o (server_ident_o)
  );

endmodule

`default_nettype wire
